// ===== hw/rtl/battery_supervisor_fsm_unit_assert.svh =====
// Assertion macros shared by the supervisor RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef BATTERY_SUPERVISOR_FSM_UNIT_ASSERT_SVH
`define BATTERY_SUPERVISOR_FSM_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define BSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define BSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/bsf_pkg.sv =====
// Types, codes and transition functions of the battery supervisor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bsf_pkg;

  typedef enum logic [2:0] {
    MODE_FAULT   = 3'd0,
    MODE_STARTUP = 3'd1,
    MODE_INIT    = 3'd2,
    MODE_OPER    = 3'd3,
    MODE_LOW     = 3'd4,
    MODE_CRIT    = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    EV_FAULT_CLEARED = 3'd0,
    EV_STARTUP_DONE  = 3'd1,
    EV_INITIALIZED   = 3'd2,
    EV_FAULT         = 3'd3,
    EV_LOW           = 3'd4,
    EV_OK            = 3'd5,
    EV_CRITICAL      = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    CMD_DISPATCH = 2'd0,
    CMD_FORCE    = 2'd1,
    CMD_TICK     = 2'd2
  } cmd_e;

  localparam logic [2:0] REG_LOW_ENTER  = 3'd0;
  localparam logic [2:0] REG_CRIT_ENTER = 3'd1;
  localparam logic [2:0] REG_OK_RETURN  = 3'd2;
  localparam logic [2:0] REG_CRIT_EXIT  = 3'd3;
  localparam logic [2:0] REG_MIN_DWELL  = 3'd4;

  localparam logic [14:0] LOW_ENTER_RST  = 15'd6600;
  localparam logic [14:0] CRIT_ENTER_RST = 15'd6000;
  localparam logic [14:0] OK_RETURN_RST  = 15'd6800;
  localparam logic [14:0] CRIT_EXIT_RST  = 15'd6200;
  localparam logic [15:0] MIN_DWELL_RST  = 16'd0;

  localparam logic [2:0]  MODE_COUNT    = 3'd6;
  localparam logic [7:0]  PASS_BIT      = 8'h01;
  localparam logic [7:0]  PASSED_FLAG   = 8'h80;
  localparam logic [15:0] CHECK_RATE_HZ = 16'd10;

  typedef struct packed {
    logic [14:0] low_enter_mv;
    logic [14:0] critical_enter_mv;
    logic [14:0] ok_return_mv;
    logic [14:0] critical_exit_mv;
    logic [15:0] min_dwell_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  event_code;
    logic [2:0]  target_mode;
    logic [15:0] tick_rate_hz;
    logic [31:0] now_ms;
    logic [7:0]  selftest_bits;
    logic        read_ok;
    logic [14:0] battery_mv;
  } item_t;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] entry;
    logic [7:0]  status;
    logic [7:0]  count;
  } state_t;

  typedef struct packed {
    state_t st;
    logic   changed;
  } work_t;

  function automatic mode_e next_mode(mode_e m, logic [2:0] ev);
    mode_e r;
    r = m;
    unique case (m)
      MODE_FAULT:   if (ev == EV_FAULT_CLEARED) r = MODE_OPER;
      MODE_STARTUP: if (ev == EV_STARTUP_DONE) r = MODE_INIT;
      MODE_INIT:    if (ev == EV_INITIALIZED) r = MODE_OPER;
      MODE_OPER: begin
        if (ev == EV_FAULT) r = MODE_FAULT;
        else if (ev == EV_LOW) r = MODE_LOW;
      end
      MODE_LOW: begin
        if (ev == EV_FAULT) r = MODE_FAULT;
        else if (ev == EV_OK) r = MODE_OPER;
        else if (ev == EV_CRITICAL) r = MODE_CRIT;
      end
      MODE_CRIT: begin
        if (ev == EV_FAULT) r = MODE_FAULT;
        else if (ev == EV_LOW) r = MODE_LOW;
      end
      default: r = m;
    endcase
    return r;
  endfunction

  function automatic work_t enter_mode(work_t w, mode_e m, logic [31:0] now);
    work_t r;
    r = w;
    r.st.mode  = m;
    r.st.entry = now;
    if (m == MODE_FAULT) r.st.status = '0;
    r.changed = 1'b1;
    return r;
  endfunction

  // Event transition, held back while less than the dwell time has elapsed.
  function automatic work_t dispatch(work_t w, logic [2:0] ev, logic [31:0] now,
                                     logic [15:0] dwell);
    work_t       r;
    mode_e       m;
    logic [31:0] elapsed;
    logic        too_early;
    r         = w;
    m         = next_mode(w.st.mode, ev);
    elapsed   = now - w.st.entry;
    too_early = (elapsed[31:16] == '0) && (elapsed[15:0] < dwell);
    if ((m != w.st.mode) && !too_early) r = enter_mode(w, m, now);
    return r;
  endfunction

endpackage

// ===== hw/rtl/bsf_cfg.sv =====
// Configuration register file of the supervisor: thresholds and dwell time.
// Depends on bsf_pkg.
`timescale 1ns / 1ps

module bsf_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [2:0]    addr_i,
  input  logic [15:0]   wdata_i,
  output bsf_pkg::cfg_t cfg_o
);

  bsf_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (addr_i)
        bsf_pkg::REG_LOW_ENTER:  cfg_d.low_enter_mv      = wdata_i[14:0];
        bsf_pkg::REG_CRIT_ENTER: cfg_d.critical_enter_mv = wdata_i[14:0];
        bsf_pkg::REG_OK_RETURN:  cfg_d.ok_return_mv      = wdata_i[14:0];
        bsf_pkg::REG_CRIT_EXIT:  cfg_d.critical_exit_mv  = wdata_i[14:0];
        bsf_pkg::REG_MIN_DWELL:  cfg_d.min_dwell_ms      = wdata_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_enter_mv      <= bsf_pkg::LOW_ENTER_RST;
      cfg_q.critical_enter_mv <= bsf_pkg::CRIT_ENTER_RST;
      cfg_q.ok_return_mv      <= bsf_pkg::OK_RETURN_RST;
      cfg_q.critical_exit_mv  <= bsf_pkg::CRIT_EXIT_RST;
      cfg_q.min_dwell_ms      <= bsf_pkg::MIN_DWELL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/bsf_step.sv =====
// Next-state logic of the supervisor for one command beat.
// Depends on bsf_pkg; purely combinational.
`timescale 1ns / 1ps

module bsf_step (
  input  bsf_pkg::state_t st_i,
  input  bsf_pkg::item_t  item_i,
  input  bsf_pkg::cfg_t   cfg_i,
  output bsf_pkg::work_t  res_o
);

  bsf_pkg::work_t w0, wf, wa, wb, res;
  logic           at_rate;
  logic [2:0]     pass_ev;
  logic [15:0]    dwell;
  logic [31:0]    now;

  always_comb begin
    dwell      = cfg_i.min_dwell_ms;
    now        = item_i.now_ms;
    at_rate    = (item_i.tick_rate_hz == bsf_pkg::CHECK_RATE_HZ);
    w0.st      = st_i;
    w0.changed = 1'b0;
    pass_ev    = (st_i.mode == bsf_pkg::MODE_FAULT) ? bsf_pkg::EV_FAULT_CLEARED
                                                    : bsf_pkg::EV_INITIALIZED;
    // Failed sensor read raises a fault first; voltage checks then chain on.
    wf = item_i.read_ok ? w0 : bsf_pkg::dispatch(w0, bsf_pkg::EV_FAULT, now, dwell);
    wa = wf;
    wb = wf;
    res = w0;

    unique case (item_i.command)
      bsf_pkg::CMD_DISPATCH: res = bsf_pkg::dispatch(w0, item_i.event_code, now, dwell);
      bsf_pkg::CMD_FORCE: begin
        if ((item_i.target_mode < bsf_pkg::MODE_COUNT) &&
            (item_i.target_mode != st_i.mode))
          res = bsf_pkg::enter_mode(w0, bsf_pkg::mode_e'(item_i.target_mode), now);
      end
      bsf_pkg::CMD_TICK: begin
        unique case (st_i.mode)
          bsf_pkg::MODE_FAULT, bsf_pkg::MODE_INIT: begin
            if (at_rate) begin
              if ((st_i.status & bsf_pkg::PASS_BIT) == bsf_pkg::PASS_BIT) begin
                res = bsf_pkg::dispatch(w0, pass_ev, now, dwell);
                res.st.status = res.st.status | bsf_pkg::PASSED_FLAG;
              end else begin
                res.st.count  = st_i.count + 8'd1;
                res.st.status = st_i.status | item_i.selftest_bits;
              end
            end
          end
          bsf_pkg::MODE_STARTUP: res = bsf_pkg::dispatch(w0, bsf_pkg::EV_STARTUP_DONE, now, dwell);
          bsf_pkg::MODE_OPER: begin
            if (item_i.battery_mv < cfg_i.low_enter_mv)
              wa = bsf_pkg::dispatch(wf, bsf_pkg::EV_LOW, now, dwell);
            if (at_rate) res = wa;
          end
          bsf_pkg::MODE_LOW: begin
            if (item_i.battery_mv < cfg_i.critical_enter_mv)
              wa = bsf_pkg::dispatch(wf, bsf_pkg::EV_CRITICAL, now, dwell);
            wb = wa;
            if (item_i.battery_mv > cfg_i.ok_return_mv)
              wb = bsf_pkg::dispatch(wa, bsf_pkg::EV_OK, now, dwell);
            if (at_rate) res = wb;
          end
          bsf_pkg::MODE_CRIT: begin
            if (item_i.battery_mv > cfg_i.critical_exit_mv)
              wa = bsf_pkg::dispatch(wf, bsf_pkg::EV_LOW, now, dwell);
            if (at_rate) res = wa;
          end
          default: res = w0;
        endcase
      end
      default: res = w0; // unknown command: report state unchanged
    endcase
  end

  assign res_o = res;

endmodule

// ===== hw/rtl/battery_supervisor_fsm_unit.sv =====
// Top level of the six-mode battery supervisor.
// Depends on bsf_pkg, bsf_cfg, bsf_step and the assertion macro header.
`timescale 1ns / 1ps
//
// Usage
//   Commands arrive as beats on the s_axis group; each one yields exactly one
//   result beat on the m_axis group with the mode, status byte, self-test
//   count and a flag telling whether the beat changed the mode.
//   A beat is taken into an input register, then evaluated by the
//   combinational transition logic against the held supervisor state; mode,
//   entry time, status and count update in the same cycle as the result
//   register loads, and the result is valid from that register. Throughput is
//   one beat per cycle while the receiver takes every result.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more beat; s_axis_tready drops only once both
//   are full, and rises again in the cycle the result is taken.
//   The user must write thresholds and the dwell time through cfg_we_i/
//   cfg_addr_i/cfg_wdata_i only while the block is idle; the block itself
//   does not enforce this. Reset loads startup mode, zero entry time, status
//   and count, the default thresholds, and empties both registers.

module battery_supervisor_fsm_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0], event_code[4:2], target_mode[7:5], tick_rate_hz[23:8],
  // now_ms[55:24], selftest_bits[63:56], read_ok[64], battery_mv[79:65]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mode[2:0], status_byte[10:3], selftest_count[18:11], mode_changed[19],
  // zero fill[23:20]
  output logic [23:0] m_axis_tdata
);

`include "battery_supervisor_fsm_unit_assert.svh"

  bsf_pkg::cfg_t   cfg;
  bsf_pkg::item_t  item_q, item_d;
  bsf_pkg::state_t state_q, state_d;
  bsf_pkg::work_t  step;
  logic            in_vld_q, in_vld_d;
  logic            out_vld_q, out_vld_d;
  logic [19:0]     res_q, res_d;
  logic            s_acc, advance;

  bsf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  bsf_step u_step (
    .st_i   (state_q),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (step)
  );

  // Advance when an item waits and the result slot is free or being drained.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.command       = s_axis_tdata[1:0];
    item_d.event_code    = s_axis_tdata[4:2];
    item_d.target_mode   = s_axis_tdata[7:5];
    item_d.tick_rate_hz  = s_axis_tdata[23:8];
    item_d.now_ms        = s_axis_tdata[55:24];
    item_d.selftest_bits = s_axis_tdata[63:56];
    item_d.read_ok       = s_axis_tdata[64];
    item_d.battery_mv    = s_axis_tdata[79:65];

    in_vld_d  = s_acc ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    out_vld_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);
    state_d   = advance ? step.st : state_q;
    res_d     = {step.changed, step.st.count, step.st.status, step.st.mode};
  end

  // Control and supervisor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      state_q.mode   <= bsf_pkg::MODE_STARTUP;
      state_q.entry  <= '0;
      state_q.status <= '0;
      state_q.count  <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
    end
  end

  // Payload registers: hold unless a beat moves in.
  always_ff @(posedge clk_i) begin
    if (s_acc) item_q <= item_d;
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, res_q};

  `BSF_ASSERT(a_state_holds, !advance |=> $stable(state_q), "state moved without a beat")
  `BSF_ASSERT(a_changed_moves, (advance && step.changed) |=> (state_q.mode != $past(state_q.mode)), "mode_changed without a new mode")
  `BSF_ASSERT(a_fault_clears, (advance && (step.st.mode == bsf_pkg::MODE_FAULT) && (state_q.mode != bsf_pkg::MODE_FAULT)) |=> (state_q.status == '0), "status kept on fault entry")
  `BSF_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule
